FILE: src/tdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial-division prime test package
// Widths and constants shared by the prime test unit.
// ----------------------------------------------------------------------------
package tdp_pkg;

  // Width of the input field on the port
  localparam int IN_W         = 16;
  // Bits of the input that take part in the test
  localparam int NUMBER_WIDTH = 16;
  localparam int NUM_W        = (NUMBER_WIDTH < IN_W) ? NUMBER_WIDTH : IN_W;

  // Trial divisor: never above sqrt(2^NUM_W) + 1
  localparam int DIV_W = (NUM_W + 1) / 2 + 1;
  // Running square of the divisor
  localparam int SQ_W  = NUM_W + 2;
  // Partial remainder; one bit above the divisor for the shifted value
  localparam int REM_W = DIV_W + 1;
  // Bit counter over the dividend
  localparam int CNT_W = $clog2(NUM_W);

  localparam int FIRST_DIVISOR = 2;

  typedef logic [NUM_W-1:0] number_t;
  typedef logic [DIV_W-1:0] divisor_t;
  typedef logic [SQ_W-1:0]  square_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [CNT_W-1:0] bitcnt_t;

endpackage

FILE: src/trial_division_prime_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial-division prime test unit
// Tests an unsigned number for primality by trying divisors 2, 3, 4, ...
// while d*d <= number, one remainder bit per cycle while dividing.
//
//   channel  ports                     handshake
//   input    in_number[15:0]           taken when start && !busy
//   result   out_is_prime              one-cycle strobe on out_valid
//
// Each trial divisor takes one bound check against the running square, then
// 16 remainder bits through a single compare-subtract stage; the search
// stops early when a divisor is found. busy is high from acceptance until
// the result strobe; a new item may be taken in the strobe cycle.
// Reset is synchronous and clears the control state only. The receiver
// cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [tdp_pkg::IN_W-1:0] in_number,
  output logic                   out_valid,
  output logic                   out_is_prime
);
  import tdp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;

  logic [1:0] state_r, state_nxt;
  number_t    num_r, num_nxt;
  number_t    shreg_r, shreg_nxt;
  divisor_t   d_r, d_nxt;
  square_t    sq_r, sq_nxt;
  rem_t       rem_r, rem_nxt;
  bitcnt_t    cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_is_prime_r, out_is_prime_nxt;

  rem_t rem_sh;
  rem_t rem_sub;

  // One restoring-division step: bring in the next dividend bit
  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], shreg_r[NUM_W-1]};
    rem_sub = (rem_sh >= REM_W'(d_r)) ? rem_sh - REM_W'(d_r) : rem_sh;
  end

  always_comb begin
    state_nxt        = state_r;
    num_nxt          = num_r;
    shreg_nxt        = shreg_r;
    d_nxt            = d_r;
    sq_nxt           = sq_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    out_valid_nxt    = 1'b0;
    out_is_prime_nxt = out_is_prime_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          num_nxt   = in_number[NUM_W-1:0];
          d_nxt     = DIV_W'(FIRST_DIVISOR);
          sq_nxt    = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (num_r < NUM_W'(FIRST_DIVISOR)) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b0;
          state_nxt        = ST_IDLE;
        end else if (sq_r > SQ_W'(num_r)) begin
          // no divisor left below the root
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          shreg_nxt = num_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(NUM_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt   = rem_sub;
        shreg_nxt = shreg_r << 1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (rem_sub == '0) begin
            out_valid_nxt    = 1'b1;
            out_is_prime_nxt = 1'b0;
            state_nxt        = ST_IDLE;
          end else begin
            // advance: (d+1)^2 = d^2 + 2d + 1
            d_nxt     = d_r + 1'b1;
            sq_nxt    = sq_r + SQ_W'({d_r, 1'b1});
            state_nxt = ST_CHECK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r          <= num_nxt;
    shreg_r        <= shreg_nxt;
    d_r            <= d_nxt;
    sq_r           <= sq_nxt;
    rem_r          <= rem_nxt;
    cnt_r          <= cnt_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // A result is only ever posted on the way back to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while busy");

  // An accepted item passes through a bound check before its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid_r))
    else $error("accepted item did not hold the unit busy");

  // The partial remainder stays below the divisor during a division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < REM_W'(d_r)))
    else $error("partial remainder out of range");

  // The running square tracks the divisor when a bound check starts
  a_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> (sq_r == SQ_W'(d_r) * SQ_W'(d_r)))
    else $error("divisor square out of step");

endmodule

FILE: sim/trial_division_prime_test_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial-division prime test unit testbench
// Sends 16-bit numbers through the start/busy command port and checks each
// out_is_prime strobe against a primality predictor kept in the bench.
// Directed corner numbers and squares (most of primes) come first, then random
// numbers biased toward long divisor searches, under several sender idling mixes.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit_tb;

  localparam int HALF_PERIOD  = 5;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 4400;
  localparam int REPORT_MAX   = 10;

  typedef logic [tdp_pkg::IN_W-1:0] port_number_t;

  typedef struct packed {
    port_number_t number;
    logic         is_prime;
  } verdict_t;

  logic         clk;
  logic         rst_n;
  logic         start;
  logic         busy;
  port_number_t in_number;
  logic         out_valid;
  logic         out_is_prime;

  verdict_t     verdicts_q[$];
  int           mismatch_count;
  longint       cycle_count;

  trial_division_prime_test_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

  // Start low so that the first rising edge comes after time zero
  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  // Trial division on the bits that take part in the test
  function automatic logic primality_of(input port_number_t value);
    longint unsigned n;
    longint unsigned d;
    n = longint'(value) & ((64'd1 << tdp_pkg::NUM_W) - 1);
    if (n < tdp_pkg::FIRST_DIVISOR) return 1'b0;
    for (d = tdp_pkg::FIRST_DIVISOR; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               verdicts_q.size());
      $display("trial_division_prime_test_unit_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid) begin
      if (verdicts_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: out_is_prime %0b with no item pending",
                   out_is_prime);
      end else begin
        want = verdicts_q.pop_front();
        if (out_is_prime !== want.is_prime) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("number %0d: out_is_prime expected %0b got %0b",
                     want.number, want.is_prime, out_is_prime);
        end
      end
    end
  end

  // Leave start high after acceptance; a gap in the next call or wait_for_results lowers it
  task automatic send_number(input port_number_t value, input int gap_pct);
    verdict_t entry;
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    start     <= 1'b1;
    in_number <= value;
    do @(posedge clk); while (busy);
    entry.number   = value;
    entry.is_prime = primality_of(value);
    verdicts_q.push_back(entry);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_numbers();
    port_number_t corners[$];
    corners = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5, 16'd65535, 16'd65534,
                16'd65521, 16'd32768, 16'h5555, 16'hAAAA, 16'd64507};
    foreach (corners[i]) send_number(corners[i], 0);
    wait_for_results();
  endtask

  task automatic test_prime_squares();
    port_number_t squares[$];
    squares = '{16'd4, 16'd9, 16'd25, 16'd49, 16'd121, 16'd58081, 16'd63001,
                16'd65025};
    foreach (squares[i]) send_number(squares[i], 0);
    wait_for_results();
  endtask

  // Mix full-range values with small ones, odd products and squares so that
  // many items run deep into the divisor search
  task automatic test_random_numbers(input int count, input int gap_pct);
    int           pick;
    int           low_factor;
    int           high_factor;
    port_number_t value;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        value = port_number_t'($urandom());
      end else if (pick < 70) begin
        value = port_number_t'($urandom_range(1023));
      end else if (pick < 85) begin
        low_factor  = $urandom_range(60, 255) | 1;
        high_factor = $urandom_range(low_factor, 65535 / low_factor) | 1;
        if (low_factor * high_factor > 65535) high_factor = high_factor - 2;
        value = port_number_t'(low_factor * high_factor);
      end else begin
        low_factor = $urandom_range(2, 255);
        value = port_number_t'(low_factor * low_factor);
      end
      send_number(value, gap_pct);
    end
    wait_for_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_number      = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_numbers();
    test_prime_squares();
    test_random_numbers(40, 0);
    test_random_numbers(40, 83);
    test_random_numbers(40, 7);

    // Catch any stray strobe after the last result
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += verdicts_q.size();
    if (mismatch_count == 0) begin
      $display("trial_division_prime_test_unit_tb: clean");
    end else begin
      $display("trial_division_prime_test_unit_tb: errors");
    end
    $finish;
  end

endmodule
